### src/ssfe_pkg.sv
// Shared types and constants for the start/stop frame echo block.
// No dependencies; imported by every module of the block.
package ssfe_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] START_RESET = 8'd255;
   localparam logic [BYTE_W-1:0] STOP_RESET  = 8'd251;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_IDX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_IDX  = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } ssfe_qstat_type;

endpackage

### src/ssfe_front.sv
// Front end: accepts received bytes, classifies them, keeps the payload store
// and builds one reply entry per stop byte. Depends on ssfe_pkg.
module ssfe_front
   import ssfe_pkg::*;
#(
   parameter int STORE_DEPTH  = 16,
   parameter int REPLY_LENGTH = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [BYTE_W-1:0]                     req_tdata,
   input  logic                                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                  csr_index,
   input  logic [BYTE_W-1:0]                     csr_wdata,
   input  ssfe_qstat_type                        q_stat,
   output logic                                  q_push,
   output logic [(REPLY_LENGTH+2)*BYTE_W-1:0]    q_entry
);

   localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(STORE_DEPTH);

   logic [BYTE_W-1:0] start_ff, start_in;
   logic [BYTE_W-1:0] stop_ff, stop_in;
   logic              armed_ff, armed_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0] store_ff [STORE_DEPTH];
   logic              accept;
   logic              is_start;
   logic              is_stop;
   logic              store_wr;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = (req_tdata == start_ff);
   assign is_stop    = !is_start && (req_tdata == stop_ff);
   assign store_wr   = accept && !is_start && !is_stop && armed_ff && (index_ff < IDX_FULL);
   assign q_push     = accept && is_stop;

   always_comb begin
      start_in = start_ff;
      stop_in  = stop_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_IDX: start_in = csr_wdata;
            CSR_STOP_IDX:  stop_in  = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      armed_in = armed_ff;
      index_in = index_ff;
      if (accept && is_start) begin
         armed_in = 1'b1;
         index_in = '0;
      end else if (accept && is_stop) begin
         armed_in = 1'b0;
         index_in = '0;
      end else if (store_wr) begin
         index_in = index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         stop_ff  <= STOP_RESET;
         armed_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         start_ff <= start_in;
         stop_ff  <= stop_in;
         armed_ff <= armed_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_wr) begin
         store_ff[index_ff[ADDR_W-1:0]] <= req_tdata;
      end
   end

   assign q_entry[BYTE_W-1:0] = start_ff;
   assign q_entry[(REPLY_LENGTH+2)*BYTE_W-1 -: BYTE_W] = stop_ff;

   for (genvar k = 0; k < REPLY_LENGTH; k++) begin : g_snap
      if (k < STORE_DEPTH) begin : g_store
         assign q_entry[(k+1)*BYTE_W +: BYTE_W] = store_ff[k];
      end else begin : g_zero
         assign q_entry[(k+1)*BYTE_W +: BYTE_W] = '0;
      end
   end

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_FULL)
      else $error("write index beyond store depth");

   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !armed_ff && index_ff == '0)
      else $error("stop byte did not disarm");

   a_unarmed_hold: assert property (@(posedge clock) disable iff (reset)
      !armed_ff && !(accept && is_start) |=> index_ff == '0)
      else $error("index moved while disarmed");

endmodule

### src/ssfe_queue.sv
// Two-entry queue of reply entries between front and back end.
// Depends on ssfe_pkg.
module ssfe_queue
   import ssfe_pkg::*;
#(
   parameter int ENTRY_W = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [ENTRY_W-1:0] push_entry,
   input  logic               pop,
   output logic [ENTRY_W-1:0] head_entry,
   output ssfe_qstat_type     stat
);

   logic [ENTRY_W-1:0] mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign stat.full   = (count_ff == 2'd2);
   assign stat.empty  = (count_ff == 2'd0);
   assign head_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop)
      else $error("pop from empty queue");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

### src/ssfe_back.sv
// Back end: serializes the head reply entry into the output register,
// one byte per cycle unless held by rsp_tready or an empty queue, marking the stop byte as last. Depends on ssfe_pkg.
module ssfe_back
   import ssfe_pkg::*;
#(
   parameter int REPLY_LENGTH = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssfe_qstat_type                     q_stat,
   input  logic [(REPLY_LENGTH+2)*BYTE_W-1:0] q_head,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [BYTE_W-1:0]                  rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int FRAME_LEN = REPLY_LENGTH + 2;
   localparam int CNT_W     = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

   logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic              advance;
   logic              load;
   logic              at_last;

   for (genvar k = 0; k < FRAME_LEN; k++) begin : g_unpack
      assign frame_bytes[k] = q_head[k*BYTE_W +: BYTE_W];
   end

   assign advance = !valid_ff || rsp_tready;
   assign load    = advance && !q_stat.empty;
   assign at_last = (cnt_ff == LAST_POS);
   assign q_pop   = load && at_last;

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = frame_bytes[cnt_ff];
         last_in  = at_last;
         cnt_in   = at_last ? '0 : cnt_ff + 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_POS)
      else $error("byte counter out of range");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> cnt_ff == '0)
      else $error("counter busy with no entry");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> cnt_ff == '0)
      else $error("counter not wrapped after last byte");

endmodule

### src/start_stop_frame_echo.sv
// Start/stop frame echo: top level joining front end, reply queue and back end.
// Depends on ssfe_pkg, ssfe_front, ssfe_queue and ssfe_back.
//
// Usage:
//   req_* carries received bytes, one item per handshake. A start byte arms
//   the block and clears the write index; armed data bytes fill the payload
//   store (extra bytes past the store depth are dropped); a stop byte queues a
//   reply. Other bytes give no output.
//   rsp_* carries the reply: start byte, the first REPLY_LENGTH stored bytes
//   (zero past the store), then the stop byte with rsp_tlast high, so
//   REPLY_LENGTH + 2 items per stop byte, one per cycle while rsp_tready is
//   high. rsp_tvalid rises once the stop byte's entry has passed through the
//   reply queue into the back end's output register. The back end's byte
//   counter paces the output, stepping through each reply item by item.
//   Up to two replies wait in the queue; req_tready drops only when it is
//   full, so a stalled receiver backs up the input after two stop bytes.
//   csr_* writes start_byte (index 0) and stop_byte (index 1).
//   Reset is synchronous: it disarms, clears the store and queue, and loads
//   start_byte = 255 and stop_byte = 251.
module start_stop_frame_echo
   import ssfe_pkg::*;
#(
   parameter int STORE_DEPTH  = 16,
   parameter int REPLY_LENGTH = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,   // [7:0] tx_byte
   output logic                 rsp_tlast,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam int ENTRY_W = (REPLY_LENGTH + 2) * BYTE_W;

   ssfe_qstat_type     q_stat;
   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_entry;
   logic [ENTRY_W-1:0] q_head;

   ssfe_front #(
      .STORE_DEPTH  (STORE_DEPTH),
      .REPLY_LENGTH (REPLY_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   ssfe_queue #(
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .stat       (q_stat)
   );

   ssfe_back #(
      .REPLY_LENGTH (REPLY_LENGTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
